/* design/atrlc_pkg.sv */
// ----------------------------------------------------------------------------
// AT response line classifier package
// Shared types, prefix tables and helper functions for the line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package atrlc_pkg;

	// Default maximum number of bytes held in one line.
	localparam int unsigned LINE_BUFFER_DEPTH_DEF = 256;

	// Width of the line length field on the result channel.
	localparam int unsigned LENGTH_W = 9;

	// Prefix table geometry.
	localparam int unsigned PFX_NUM     = 31;
	localparam int unsigned PFX_MAX_LEN = 19;
	localparam int unsigned PFX_LEN_W   = 5;

	// Line terminators.
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	// Class codes given for a finished line.
	typedef enum logic [4:0] {
		CLS_UNKNOWN     = 5'd0,
		CLS_BOOT        = 5'd1,
		CLS_CNUM        = 5'd2,
		CLS_OK          = 5'd3,
		CLS_RSSI        = 5'd4,
		CLS_MODE        = 5'd5,
		CLS_CEND        = 5'd6,
		CLS_CSSI        = 5'd7,
		CLS_ORIG        = 5'd8,
		CLS_CONF        = 5'd9,
		CLS_CONN        = 5'd10,
		CLS_CREG        = 5'd11,
		CLS_COPS        = 5'd12,
		CLS_SRVST       = 5'd13,
		CLS_CSQ         = 5'd14,
		CLS_CPIN        = 5'd15,
		CLS_RING        = 5'd16,
		CLS_CLIP        = 5'd17,
		CLS_ERROR       = 5'd18,
		CLS_CMTI        = 5'd19,
		CLS_CMGR        = 5'd20,
		CLS_CSSU        = 5'd21,
		CLS_BUSY        = 5'd22,
		CLS_NO_DIALTONE = 5'd23,
		CLS_NO_CARRIER  = 5'd24,
		CLS_CMS_ERROR   = 5'd25,
		CLS_SMMEMFULL   = 5'd26,
		CLS_SMS_PROMPT  = 5'd27,
		CLS_CUSD        = 5'd28,
		CLS_CPMS        = 5'd29
	} class_t;

	// Control from the line framer to the prefix matcher.
	typedef struct packed {
		logic absorb;   // take the byte into the line
		logic restart;  // line ended or dropped: every prefix possible again
	} match_ctrl_t;

	// Prefix text, right-justified: the first character sits in the
	// highest occupied byte.
	localparam logic [8*PFX_MAX_LEN-1:0] PFX_TEXT [PFX_NUM] = '{
		"^BOOT:",
		"+CNUM:",
		"ERROR+CNUM:",
		"OK",
		"^RSSI:",
		"^MODE:",
		"^CEND:",
		"+CSSI:",
		"^ORIG:",
		"^CONF:",
		"^CONN:",
		"+CREG:",
		"+COPS:",
		"^SRVST:",
		"+CSQ:",
		"+CPIN:",
		"RING",
		"+CLIP:",
		"ERROR",
		"+CMTI:",
		"+CMGR:",
		"+CSSU:",
		"BUSY",
		"NO DIALTONE",
		"NO CARRIER",
		"COMMAND NOT SUPPORT",
		"+CMS ERROR:",
		"^SMMEMFULL:",
		"> ",
		"+CUSD:",
		"+CPMS:"
	};

	localparam logic [PFX_LEN_W-1:0] PFX_LEN [PFX_NUM] = '{
		5'd6, 5'd6, 5'd11, 5'd2, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
		5'd6, 5'd6, 5'd6, 5'd7, 5'd5, 5'd6, 5'd4, 5'd6, 5'd5, 5'd6,
		5'd6, 5'd6, 5'd4, 5'd11, 5'd10, 5'd19, 5'd11, 5'd11, 5'd2, 5'd6,
		5'd6
	};

	localparam class_t PFX_CLASS [PFX_NUM] = '{
		CLS_BOOT, CLS_CNUM, CLS_CNUM, CLS_OK, CLS_RSSI, CLS_MODE, CLS_CEND,
		CLS_CSSI, CLS_ORIG, CLS_CONF, CLS_CONN, CLS_CREG, CLS_COPS, CLS_SRVST,
		CLS_CSQ, CLS_CPIN, CLS_RING, CLS_CLIP, CLS_ERROR, CLS_CMTI, CLS_CMGR,
		CLS_CSSU, CLS_BUSY, CLS_NO_DIALTONE, CLS_NO_CARRIER, CLS_ERROR,
		CLS_CMS_ERROR, CLS_SMMEMFULL, CLS_SMS_PROMPT, CLS_CUSD, CLS_CPMS
	};

	// Character of prefix idx at line position pos; zero past its end.
	function automatic logic [7:0] prefix_char(input int unsigned idx,
		input logic [PFX_LEN_W-1:0] pos);
		logic [8*PFX_MAX_LEN-1:0] text;
		int unsigned              len;
		int unsigned              p;
		text = PFX_TEXT[idx];
		len  = int'(PFX_LEN[idx]);
		p    = int'(pos);
		if (p >= len) begin
			return 8'h00;
		end
		return text[8*(len-1-p) +: 8];
	endfunction

endpackage

`default_nettype wire

/* design/atrlc_byte_if.sv */
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received modem byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/atrlc_line_if.sv */
// ----------------------------------------------------------------------------
// Line result channel
// Valid/ready channel carrying the class and length of one finished line.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlc_line_if;
	logic                             valid;
	logic                             ready;
	logic [4:0]                       line_class;
	logic [atrlc_pkg::LENGTH_W-1:0]   line_length;

	modport source (output valid, output line_class, output line_length, input ready);
	modport sink (input valid, input line_class, input line_length, output ready);
endinterface

`default_nettype wire

/* design/atrlc_prefix_match.sv */
// ----------------------------------------------------------------------------
// Prefix matcher
// Holds one still-possible flag per prefix, updates all of them in parallel
// for each absorbed byte and gives the class of the line held so far.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_prefix_match #(
	parameter int unsigned LINE_BUFFER_DEPTH = atrlc_pkg::LINE_BUFFER_DEPTH_DEF
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  atrlc_pkg::match_ctrl_t                    ctrl,
	input  wire  [7:0]                                rx_byte,
	input  wire  [$clog2(LINE_BUFFER_DEPTH+1)-1:0]    fill_count,
	output atrlc_pkg::class_t                         line_class
);

	localparam int unsigned CNT_W = $clog2(LINE_BUFFER_DEPTH + 1);

	logic [atrlc_pkg::PFX_NUM-1:0] flags_q;
	logic [atrlc_pkg::PFX_NUM-1:0] keep;
	logic [atrlc_pkg::PFX_NUM-1:0] hit;

	// Per prefix: does the byte at this position still agree, and is the
	// line long enough with every byte so far agreeing.
	always_comb begin
		for (int i = 0; i < atrlc_pkg::PFX_NUM; i++) begin
			keep[i] = 1'b1;
			if (fill_count < CNT_W'(atrlc_pkg::PFX_LEN[i])) begin
				keep[i] = (rx_byte == atrlc_pkg::prefix_char(i,
					fill_count[atrlc_pkg::PFX_LEN_W-1:0]));
			end
			hit[i] = flags_q[i] && (fill_count >= CNT_W'(atrlc_pkg::PFX_LEN[i]));
		end
	end

	// Flag register: restart opens every prefix again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '1;
		end else if (ctrl.restart) begin
			flags_q <= '1;
		end else if (ctrl.absorb) begin
			flags_q <= flags_q & keep;
		end
	end

	// Priority selection: the lowest numbered matching prefix wins.
	always_comb begin
		line_class = atrlc_pkg::CLS_UNKNOWN;
		for (int i = atrlc_pkg::PFX_NUM - 1; i >= 0; i--) begin
			if (hit[i]) begin
				line_class = atrlc_pkg::PFX_CLASS[i];
			end
		end
	end

endmodule

`default_nettype wire

/* design/at_response_line_classifier.sv */
// ----------------------------------------------------------------------------
// AT response line classifier
// Cuts the modem byte stream into lines and classifies each by its prefix.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and never stalls the byte channel
// unless a result is waiting unaccepted and another byte is already held.
// Each accepted byte is registered, then framed and compared against all 31
// prefixes as it moves on from the input register; the class and length of a
// line are written into the result register as its terminating CR or LF moves
// on. The single compare stage between the input and result registers sets
// the rate of one byte per cycle. Separators between lines give no
// transaction; a byte that arrives on a full line is dropped and the line
// restarts empty without a result.
`default_nettype none

module at_response_line_classifier #(
	parameter int unsigned LINE_BUFFER_DEPTH = atrlc_pkg::LINE_BUFFER_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	atrlc_byte_if.sink   rx,
	atrlc_line_if.source lines
);

	localparam int unsigned CNT_W = $clog2(LINE_BUFFER_DEPTH + 1);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Line framing state.
	logic             in_line_q;
	logic [CNT_W-1:0] fill_count_q;

	// Result register.
	logic                             out_valid_q;
	atrlc_pkg::class_t                class_q;
	logic [atrlc_pkg::LENGTH_W-1:0]   length_q;

	logic                   advance;
	logic                   fire;
	logic                   sep;
	logic                   full;
	logic                   emit;
	atrlc_pkg::match_ctrl_t ctrl;
	atrlc_pkg::class_t      match_class;
	logic [CNT_W+atrlc_pkg::LENGTH_W-1:0] count_ext;

	// Handshake: the held byte moves on whenever the result register is free
	// or being emptied.
	assign advance  = !out_valid_q || lines.ready;
	assign fire     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Framing decisions for the held byte.
	always_comb begin
		sep          = (byte_s1 == atrlc_pkg::BYTE_CR) || (byte_s1 == atrlc_pkg::BYTE_LF);
		full         = (fill_count_q == CNT_W'(LINE_BUFFER_DEPTH));
		emit         = fire && !full && in_line_q && sep;
		ctrl.absorb  = fire && !full && !sep;
		ctrl.restart = fire && (full || emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q    <= 1'b0;
			fill_count_q <= '0;
		end else begin
			if (ctrl.restart) begin
				fill_count_q <= '0;
			end else if (ctrl.absorb) begin
				fill_count_q <= fill_count_q + CNT_W'(1);
			end
			if (ctrl.absorb) begin
				in_line_q <= 1'b1;
			end else if (emit) begin
				in_line_q <= 1'b0;
			end
		end
	end

	atrlc_prefix_match #(
		.LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.rx_byte    (byte_s1),
		.fill_count (fill_count_q),
		.line_class (match_class)
	);

	// The line length is reported modulo 2**LENGTH_W, the range of the length field.
	assign count_ext = {{atrlc_pkg::LENGTH_W{1'b0}}, fill_count_q};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			class_q  <= match_class;
			length_q <= count_ext[atrlc_pkg::LENGTH_W-1:0];
		end
	end

	assign lines.valid       = out_valid_q;
	assign lines.line_class  = class_q;
	assign lines.line_length = length_q;

endmodule

`default_nettype wire

/* design/atrlc_checker.sv */
// ----------------------------------------------------------------------------
// AT response line classifier checker
// Port-level assertions on the byte and line channels of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module atrlc_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_ready,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire [4:0]                           out_class,
	input wire [atrlc_pkg::LENGTH_W-1:0]       out_length
);

	// A stalled result keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
	else $error("result valid dropped while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_class) && $stable(out_length))
	else $error("result payload changed while stalled");

	// The byte channel only stalls behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("byte channel stalled with the result side free");

	// A fresh result follows an accepted byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result without a terminating byte");

endmodule

bind at_response_line_classifier atrlc_checker u_atrlc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (rx.valid),
	.in_ready   (rx.ready),
	.out_valid  (lines.valid),
	.out_ready  (lines.ready),
	.out_class  (lines.line_class),
	.out_length (lines.line_length)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// AT response line classifier testbench
// Feeds modem bytes into the classifier and checks every line result against
// a predictor of the framing and prefix matching. A short table of directed
// bytes comes first. Random response lines, noise and over-long lines follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import atrlc_pkg::*;

	localparam int unsigned LINE_DEPTH   = 256;
	localparam int          NUM_PREFIXES = 31;
	localparam int          RANDOM_ITEMS = 1350;
	localparam logic [7:0]  CHAR_CR      = 8'h0D;
	localparam logic [7:0]  CHAR_LF      = 8'h0A;

	typedef struct {
		class_t     cls;
		logic [8:0] len;
	} line_result_t;

	typedef struct {
		logic [7:0] rx_byte;
		bit         typed;
		class_t     cls;
		logic [8:0] len;
	} dir_row_t;

	// Prefixes in priority order, with the class each one gives.
	string prefix_txt [NUM_PREFIXES] = '{
		"^BOOT:", "+CNUM:", "ERROR+CNUM:", "OK", "^RSSI:", "^MODE:", "^CEND:",
		"+CSSI:", "^ORIG:", "^CONF:", "^CONN:", "+CREG:", "+COPS:", "^SRVST:",
		"+CSQ:", "+CPIN:", "RING", "+CLIP:", "ERROR", "+CMTI:", "+CMGR:",
		"+CSSU:", "BUSY", "NO DIALTONE", "NO CARRIER", "COMMAND NOT SUPPORT",
		"+CMS ERROR:", "^SMMEMFULL:", "> ", "+CUSD:", "+CPMS:"
	};
	class_t prefix_cls [NUM_PREFIXES] = '{
		CLS_BOOT, CLS_CNUM, CLS_CNUM, CLS_OK, CLS_RSSI, CLS_MODE, CLS_CEND,
		CLS_CSSI, CLS_ORIG, CLS_CONF, CLS_CONN, CLS_CREG, CLS_COPS, CLS_SRVST,
		CLS_CSQ, CLS_CPIN, CLS_RING, CLS_CLIP, CLS_ERROR, CLS_CMTI, CLS_CMGR,
		CLS_CSSU, CLS_BUSY, CLS_NO_DIALTONE, CLS_NO_CARRIER, CLS_ERROR,
		CLS_CMS_ERROR, CLS_SMMEMFULL, CLS_SMS_PROMPT, CLS_CUSD, CLS_CPMS
	};

	// Directed bytes: separators at reset, OK, extreme byte values, a line
	// that two prefixes match, and the SMS prompt.
	dir_row_t directed_rows [24] = '{
		'{CHAR_LF, 1'b0, CLS_UNKNOWN, 9'd0},
		'{CHAR_CR, 1'b0, CLS_UNKNOWN, 9'd0},
		'{"O",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"K",     1'b0, CLS_UNKNOWN, 9'd0},
		'{CHAR_CR, 1'b1, CLS_OK,      9'd2},
		'{CHAR_LF, 1'b0, CLS_UNKNOWN, 9'd0},
		'{8'h00,   1'b0, CLS_UNKNOWN, 9'd0},
		'{8'hFF,   1'b0, CLS_UNKNOWN, 9'd0},
		'{CHAR_LF, 1'b1, CLS_UNKNOWN, 9'd2},
		'{"E",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"R",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"R",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"O",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"R",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"+",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"C",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"N",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"U",     1'b0, CLS_UNKNOWN, 9'd0},
		'{"M",     1'b0, CLS_UNKNOWN, 9'd0},
		'{":",     1'b0, CLS_UNKNOWN, 9'd0},
		'{CHAR_CR, 1'b0, CLS_UNKNOWN, 9'd0},
		'{">",     1'b0, CLS_UNKNOWN, 9'd0},
		'{" ",     1'b0, CLS_UNKNOWN, 9'd0},
		'{CHAR_LF, 1'b0, CLS_UNKNOWN, 9'd0}
	};

	logic clk;
	logic arst_n;

	atrlc_byte_if rx_if ();
	atrlc_line_if line_if ();

	at_response_line_classifier #(
		.LINE_BUFFER_DEPTH(LINE_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.lines (line_if)
	);

	// Predictor state.
	bit          in_line_q;
	int unsigned fill_q;
	logic [NUM_PREFIXES-1:0] cand_q;

	line_result_t pending_lines [$];
	int unsigned  bytes_sent;
	int unsigned  lines_checked;
	int unsigned  full_drops;
	int unsigned  errors;
	bit           rx_calm;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Safety net against a hung handshake.
	initial begin
		#(20 * 400000);
		$display("at_response_line_classifier regression: fail");
		$finish;
	end

	// Takes one byte into the current line and drops every prefix it breaks.
	function automatic void take_line_byte(input logic [7:0] b);
		int i;
		for (i = 0; i < NUM_PREFIXES; i++) begin
			if (fill_q < prefix_txt[i].len() && b != prefix_txt[i][fill_q]) begin
				cand_q[i] = 1'b0;
			end
		end
		fill_q++;
	endfunction

	// Predicts the effect of one accepted byte; done marks a finished line.
	function automatic void classify_rx_byte(input logic [7:0] b, output bit done,
		output line_result_t res);
		bit sep;
		bit found;
		int i;
		done = 1'b0;
		res  = '{CLS_UNKNOWN, 9'd0};
		sep  = (b == CHAR_CR) || (b == CHAR_LF);
		if (fill_q >= LINE_DEPTH) begin
			// Full line: the byte is lost and matching starts again.
			fill_q = 0;
			cand_q = '1;
			full_drops++;
		end else if (!in_line_q) begin
			if (!sep) begin
				in_line_q = 1'b1;
				take_line_byte(b);
			end
		end else if (sep) begin
			found = 1'b0;
			for (i = 0; i < NUM_PREFIXES; i++) begin
				if (!found && cand_q[i] && fill_q >= prefix_txt[i].len()) begin
					res.cls = prefix_cls[i];
					found   = 1'b1;
				end
			end
			res.len   = fill_q[8:0];
			done      = 1'b1;
			in_line_q = 1'b0;
			fill_q    = 0;
			cand_q    = '1;
		end else begin
			take_line_byte(b);
		end
	endfunction

	function automatic logic [7:0] rand_text_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	// Offers one byte, waits for the transaction and records its prediction.
	task automatic send_rx(input logic [7:0] b, input bit use_typed,
		input line_result_t typed_res);
		int           gap;
		bit           done;
		line_result_t res;
		if (bytes_sent % 32 == 0) begin
			rx_calm = ($urandom_range(0, 3) == 0);
		end
		gap = rx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		bytes_sent++;
		classify_rx_byte(b, done, res);
		if (done || use_typed) begin
			pending_lines.push_back(use_typed ? typed_res : res);
		end
	endtask

	// Builds one random stretch of the byte stream and sends it.
	task automatic send_random_line(input int idx);
		logic [7:0]   seq [$];
		line_result_t none;
		string        s;
		int           kind;
		int           n;
		int           k;
		int           p;
		none = '{CLS_UNKNOWN, 9'd0};
		repeat ($urandom_range(0, 2)) seq.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
		if (idx % 50 == 25) begin
			// Over-long line around the buffer depth, then an extra terminator
			// so that an empty line follows a full one.
			n = $urandom_range(LINE_DEPTH - 1, LINE_DEPTH + 2);
			if ($urandom_range(0, 1)) begin
				s = prefix_txt[$urandom_range(0, NUM_PREFIXES - 1)];
				for (k = 0; k < s.len(); k++) seq.push_back(s[k]);
			end
			while (seq.size() < n) seq.push_back(rand_text_byte());
			seq.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			if ($urandom_range(0, 2) == 0) begin
				seq.push_back("O");
				seq.push_back("K");
			end
			seq.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
		end else begin
			kind = $urandom_range(0, 9);
			if (kind <= 7) begin
				// Response line, sometimes cut short or with one byte altered.
				p = $urandom_range(0, NUM_PREFIXES - 1);
				s = prefix_txt[p];
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, s.len()) : s.len();
				k = seq.size();
				for (int j = 0; j < n; j++) seq.push_back(s[j]);
				if (kind >= 6) begin
					seq[k + $urandom_range(0, n - 1)] = rand_text_byte();
				end
				repeat ($urandom_range(0, 8)) begin
					seq.push_back(($urandom_range(0, 3) == 0) ? rand_text_byte() :
						8'($urandom_range(32, 126)));
				end
			end else begin
				// Noise, separators included.
				repeat ($urandom_range(1, 12)) seq.push_back(8'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 3))
				0: begin
					seq.push_back(CHAR_CR);
				end
				1: begin
					seq.push_back(CHAR_LF);
				end
				2: begin
					seq.push_back(CHAR_CR);
					seq.push_back(CHAR_LF);
				end
				default: begin
					seq.push_back(CHAR_LF);
					seq.push_back(CHAR_CR);
				end
			endcase
		end
		foreach (seq[i]) send_rx(seq[i], 1'b0, none);
	endtask

	// Stimulus.
	initial begin
		line_result_t typed_res;
		int           line_idx;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		in_line_q     = 1'b0;
		fill_q        = 0;
		cand_q        = '1;
		bytes_sent    = 0;
		lines_checked = 0;
		full_drops    = 0;
		errors        = 0;
		rx_calm       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed_res = '{directed_rows[i].cls, directed_rows[i].len};
			send_rx(directed_rows[i].rx_byte, directed_rows[i].typed, typed_res);
		end

		line_idx = 0;
		while (bytes_sent < RANDOM_ITEMS) begin
			send_random_line(line_idx);
			line_idx++;
		end
		rx_if.valid <= 1'b0;

		while (pending_lines.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d random stretches; checked %0d line results.",
			bytes_sent, line_idx, lines_checked);
		$display("Full-line drops predicted: %0d.", full_drops);
		if (errors == 0 && pending_lines.size() == 0) begin
			$display("at_response_line_classifier regression: pass");
		end else begin
			$display("at_response_line_classifier regression: fail");
		end
		$finish;
	end

	// Result side: random stalls between transactions, with calm stretches.
	initial begin
		int  stall;
		int  taken;
		bit  calm;
		line_if.ready = 1'b0;
		taken         = 0;
		calm          = 1'b0;
		@(posedge clk);
		forever begin
			if (taken % 16 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				line_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			line_if.ready <= 1'b1;
			@(posedge clk);
			while (!line_if.valid) @(posedge clk);
			taken++;
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin : check_lines
		line_result_t want;
		if (arst_n && line_if.valid && line_if.ready) begin
			if (pending_lines.size() == 0) begin
				errors++;
				$display("%0t: unexpected line result class %0d length %0d", $time,
					line_if.line_class, line_if.line_length);
			end else begin
				want = pending_lines.pop_front();
				lines_checked++;
				if (line_if.line_class !== want.cls) begin
					errors++;
					$display("%0t: line_class expected %0d actual %0d", $time,
						want.cls, line_if.line_class);
				end
				if (line_if.line_length !== want.len) begin
					errors++;
					$display("%0t: line_length expected %0d actual %0d", $time,
						want.len, line_if.line_length);
				end
			end
		end
	end

endmodule

`default_nettype wire
